// ===== rtl/core/cdm_pkg.sv =====
// Shared types, constants and table builders for the curvature drive mixer.
package cdm_pkg;

	localparam int DATA_W        = 24;
	localparam int FRAC_BITS_DEF = 14;
	localparam int COUNT_MAX     = 127;
	localparam int COUNT_TAB_N   = 256;
	localparam int SHAPE_ROM_N   = 128;

	// Sine argument 0.3*pi in unsigned Q30.
	localparam logic [63:0] SHAPE_ANGLE_Q30 = 64'd1011977827;

	typedef logic signed [DATA_W-1:0] q_t;
	typedef logic signed [DATA_W+7:0] ext_t;

	localparam ext_t SAT_HI = ext_t'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
	localparam ext_t SAT_LO = ext_t'(-(64'sd1 <<< (DATA_W - 1)));

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_TURN,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_ANG,
		ST_SUM,
		ST_SPILL,
		ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_MUL1,
		OP_TURN,
		OP_MUL2,
		OP_MUL3,
		OP_MUL4,
		OP_ANG,
		OP_SUM,
		OP_SPILL
	} op_t;

	typedef struct packed {
		logic in_load;
		logic out_load;
		op_t  op;
	} dp_cmd_t;

	typedef logic [SHAPE_ROM_N-1:0][DATA_W-1:0] shape_rom_t;
	typedef logic [COUNT_TAB_N-1:0][DATA_W-1:0] count_tab_t;

	function automatic q_t sat_q(input ext_t v);
		q_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[DATA_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// Taylor series of sin() through the 13th power, unsigned Q30.
	function automatic logic [63:0] sine_q30(input logic [63:0] a);
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] sum;
		a2   = (a * a) >> 30;
		term = a;
		sum  = a;
		term = ((term * a2) >> 30) / 64'd6;
		sum  = sum - term;
		term = ((term * a2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * a2) >> 30) / 64'd42;
		sum  = sum - term;
		term = ((term * a2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * a2) >> 30) / 64'd110;
		sum  = sum - term;
		term = ((term * a2) >> 30) / 64'd156;
		sum  = sum + term;
		return sum;
	endfunction

	// Normalizing denominator sin(0.3*pi) in unsigned Q30.
	localparam logic [63:0] SHAPE_DENOM = sine_q30(SHAPE_ANGLE_Q30);

	// Entry c holds f(f(f(c/127))) in Q, f(x) = sin(0.3*pi*x) / sin(0.3*pi).
	function automatic shape_rom_t build_shape_rom(input int fb);
		shape_rom_t  rom;
		logic [63:0] x;
		logic [63:0] s;
		logic [63:0] e;
		rom = '0;
		for (int c = 0; c < SHAPE_ROM_N; c++) begin
			x = ((64'(c) << 30) + 64'd63) / 64'd127;
			for (int p = 0; p < 3; p++) begin
				s = sine_q30((x * SHAPE_ANGLE_Q30) >> 30);
				x = ((s << 30) + (SHAPE_DENOM >> 1)) / SHAPE_DENOM;
			end
			e = (x + (64'd1 << (29 - fb))) >> (30 - fb);
			rom[c] = e[DATA_W-1:0];
		end
		return rom;
	endfunction

	// Entry c holds c * 2^fb / 127 truncated, for joystick counts and differences.
	function automatic count_tab_t build_count_tab(input int fb);
		count_tab_t  tab;
		logic [63:0] v;
		tab = '0;
		for (int c = 0; c < COUNT_TAB_N; c++) begin
			v = (64'(c) << fb) / 64'd127;
			tab[c] = v[DATA_W-1:0];
		end
		return tab;
	endfunction

endpackage

// ===== rtl/core/cdm_ctrl.sv =====
// Sequencing controller: walks one sample through the shared datapath.
module cdm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output cdm_pkg::dp_cmd_t cmd
);
	import cdm_pkg::*;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n      = state_q;
		cmd.in_load  = 1'b0;
		cmd.out_load = 1'b0;
		cmd.op       = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_n     = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.op  = OP_MUL1;
				state_n = ST_TURN;
			end
			ST_TURN: begin
				cmd.op  = OP_TURN;
				state_n = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.op  = OP_MUL2;
				state_n = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.op  = OP_MUL3;
				state_n = ST_MUL4;
			end
			ST_MUL4: begin
				cmd.op  = OP_MUL4;
				state_n = ST_ANG;
			end
			ST_ANG: begin
				cmd.op  = OP_ANG;
				state_n = ST_SUM;
			end
			ST_SUM: begin
				cmd.op  = OP_SUM;
				state_n = ST_SPILL;
			end
			ST_SPILL: begin
				cmd.op  = OP_SPILL;
				state_n = ST_FIN;
			end
			ST_FIN: begin
				// The output register may still hold the previous request.
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("controller not busy after accepting a request");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result presented before the sequence finished");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && out_valid_q && out_stall |=> state_q == ST_FIN)
		else $error("pending result overwritten while stalled");
`endif

endmodule

// ===== rtl/core/cdm_dp.sv =====
// Datapath: lookup tables, shared fixed-point multiplier, mixing and output scaling.
module cdm_dp #(
	parameter int FRACTION_BITS = cdm_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cdm_pkg::dp_cmd_t  cmd,
	input  logic signed [7:0] throttle,
	input  logic signed [7:0] wheel,
	input  logic              quick_turn,
	output logic signed [7:0] left_drive,
	output logic signed [7:0] right_drive
);
	import cdm_pkg::*;

	localparam q_t Q_ONE     = q_t'(1 << FRACTION_BITS);
	localparam q_t Q_NEG_ONE = q_t'(-(1 << FRACTION_BITS));
	localparam q_t Q_THREE   = q_t'(3 << FRACTION_BITS);
	localparam q_t Q_FIVE    = q_t'(5 << FRACTION_BITS);
	localparam q_t C_3_2     = q_t'(((3 << FRACTION_BITS) + 1) / 2);
	localparam q_t C_13_20   = q_t'(((65 << FRACTION_BITS) + 50) / 100);
	localparam q_t C_4_5     = q_t'(((4 << FRACTION_BITS) + 2) / 5);
	localparam q_t C_1_5     = q_t'(((1 << FRACTION_BITS) + 2) / 5);
	localparam q_t C_11_10   = q_t'(((11 << FRACTION_BITS) + 5) / 10);
	localparam q_t C_9_10    = q_t'(((9 << FRACTION_BITS) + 5) / 10);
	localparam q_t C_1_10    = q_t'(((1 << FRACTION_BITS) + 5) / 10);

	localparam logic [2*DATA_W-1:0] MAG_MAX = (2 * DATA_W)'((64'd1 << (DATA_W - 1)) - 64'd1);
	localparam logic [2*DATA_W-1:0] MAG_MIN = (2 * DATA_W)'(64'd1 << (DATA_W - 1));
	localparam logic [DATA_W-1:0]   DRV_MAX = DATA_W'(COUNT_MAX);

	localparam shape_rom_t SHAPE_ROM = build_shape_rom(FRACTION_BITS);
	localparam count_tab_t COUNT_TAB = build_count_tab(FRACTION_BITS);

	// Signed Q product, truncated toward zero and saturated.
	function automatic q_t qmul(input q_t a, input q_t b);
		logic signed [2*DATA_W-1:0] p;
		logic [2*DATA_W-1:0]        mag;
		logic [2*DATA_W-1:0]        sh;
		q_t                         r;
		p   = a * b;
		mag = p[2*DATA_W-1] ? (2 * DATA_W)'(-p) : (2 * DATA_W)'(p);
		sh  = mag >> FRACTION_BITS;
		if (!p[2*DATA_W-1]) begin
			r = (sh > MAG_MAX) ? MAG_MAX[DATA_W-1:0] : sh[DATA_W-1:0];
		end else begin
			r = (sh > MAG_MIN) ? MAG_MIN[DATA_W-1:0] : -sh[DATA_W-1:0];
		end
		return r;
	endfunction

	// Scale by 127, saturate, truncate toward zero and clamp to a motor count.
	function automatic logic signed [7:0] drive_out(input q_t v);
		ext_t              vx;
		ext_t              d;
		q_t                ds;
		logic [DATA_W-1:0] mag;
		logic [DATA_W-1:0] sh;
		logic signed [7:0] m8;
		vx  = ext_t'(v);
		d   = (vx <<< 7) - vx;
		ds  = sat_q(d);
		mag = ds[DATA_W-1] ? -ds : ds;
		sh  = mag >> FRACTION_BITS;
		m8  = (sh > DRV_MAX) ? 8'(COUNT_MAX) : {1'b0, sh[6:0]};
		return ds[DATA_W-1] ? -m8 : m8;
	endfunction

	logic signed [7:0] prev_wheel_q;
	q_t                acc_q;
	q_t                tq_q;
	q_t                inertia_q;
	q_t                shaped_q;
	logic              quick_q;
	q_t                turn_q;
	q_t                mul_q;
	q_t                r2_q;
	q_t                ang_q;
	q_t                left_q;
	q_t                right_q;
	logic signed [7:0] left_drive_q;
	logic signed [7:0] right_drive_q;

	logic signed [7:0] t_c;
	logic signed [7:0] w_c;
	logic [6:0]        t_mag;
	logic [6:0]        w_mag;
	logic signed [8:0] d_w;
	logic [7:0]        d_mag;
	q_t                t_lut;
	q_t                d_lut;
	q_t                w_lut;
	q_t                tq_n;
	q_t                inertia_n;
	q_t                shaped_n;

	q_t   tq_abs;
	q_t   shaped_abs;
	q_t   scalar;
	q_t   lim;
	q_t   mul_a;
	q_t   mul_b;
	q_t   mul_res;
	q_t   ang_n;
	q_t   acc_n;
	q_t   sum_l;
	q_t   sum_r;
	q_t   sp_l;
	q_t   sp_r;
	logic same_sign;

	// Sample capture: a count of -128 behaves as -127.
	always_comb begin
		t_c       = (throttle == -8'sd128) ? -8'sd127 : throttle;
		w_c       = (wheel == -8'sd128) ? -8'sd127 : wheel;
		t_mag     = t_c[7] ? 7'(-t_c) : t_c[6:0];
		w_mag     = w_c[7] ? 7'(-w_c) : w_c[6:0];
		d_w       = 9'(w_c) - 9'(prev_wheel_q);
		d_mag     = d_w[8] ? 8'(-d_w) : d_w[7:0];
		t_lut     = COUNT_TAB[{1'b0, t_mag}];
		d_lut     = COUNT_TAB[d_mag];
		w_lut     = SHAPE_ROM[w_mag];
		tq_n      = t_c[7] ? -t_lut : t_lut;
		inertia_n = d_w[8] ? -d_lut : d_lut;
		shaped_n  = w_c[7] ? -w_lut : w_lut;
	end

	always_comb begin
		tq_abs     = tq_q[DATA_W-1] ? -tq_q : tq_q;
		shaped_abs = shaped_q[DATA_W-1] ? -shaped_q : shaped_q;
		same_sign  = (shaped_q > 0 && inertia_q > 0) || (shaped_q < 0 && inertia_q < 0);
		if (same_sign) begin
			scalar = C_3_2;
		end else if (shaped_abs > C_13_20) begin
			scalar = Q_FIVE;
		end else begin
			scalar = Q_THREE;
		end
		if (turn_q >= Q_ONE) begin
			lim = Q_ONE;
		end else if (turn_q <= Q_NEG_ONE) begin
			lim = Q_NEG_ONE;
		end else begin
			lim = turn_q;
		end
	end

	// Operand selection for the single shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MUL1: begin
				mul_a = inertia_q;
				mul_b = scalar;
			end
			OP_MUL2: begin
				mul_a = quick_q ? C_4_5 : turn_q;
				mul_b = quick_q ? acc_q : C_11_10;
			end
			OP_MUL3: begin
				mul_a = quick_q ? C_1_5 : tq_abs;
				mul_b = quick_q ? lim : r2_q;
			end
			OP_MUL4: begin
				mul_a = mul_q;
				mul_b = quick_q ? Q_FIVE : C_9_10;
			end
			default: begin
			end
		endcase
		mul_res = qmul(mul_a, mul_b);
	end

	// Angular term and the quick-stop update; the old level is used for the angle.
	always_comb begin
		if (quick_q) begin
			ang_n = turn_q;
			acc_n = (tq_abs < C_1_5) ? sat_q(ext_t'(r2_q) + ext_t'(mul_q)) : acc_q;
		end else begin
			ang_n = (tq_abs < C_1_10) ? turn_q : sat_q(ext_t'(mul_q) - ext_t'(acc_q));
			if (acc_q > Q_ONE) begin
				acc_n = acc_q - Q_ONE;
			end else if (acc_q < Q_NEG_ONE) begin
				acc_n = acc_q + Q_ONE;
			end else begin
				acc_n = '0;
			end
		end
	end

	always_comb begin
		sum_l = sat_q(ext_t'(tq_q) + ext_t'(ang_q));
		sum_r = sat_q(ext_t'(tq_q) - ext_t'(ang_q));
	end

	// Clamp the first side found beyond one; in quick-turn the excess spills across.
	always_comb begin
		sp_l = left_q;
		sp_r = right_q;
		if (left_q > Q_ONE) begin
			if (quick_q) begin
				sp_r = sat_q(ext_t'(right_q) - (ext_t'(left_q) - ext_t'(Q_ONE)));
			end
			sp_l = Q_ONE;
		end else if (right_q > Q_ONE) begin
			if (quick_q) begin
				sp_l = sat_q(ext_t'(left_q) - (ext_t'(right_q) - ext_t'(Q_ONE)));
			end
			sp_r = Q_ONE;
		end else if (left_q < Q_NEG_ONE) begin
			if (quick_q) begin
				sp_r = sat_q(ext_t'(right_q) + (ext_t'(Q_NEG_ONE) - ext_t'(left_q)));
			end
			sp_l = Q_NEG_ONE;
		end else if (right_q < Q_NEG_ONE) begin
			if (quick_q) begin
				sp_l = sat_q(ext_t'(left_q) + (ext_t'(Q_NEG_ONE) - ext_t'(right_q)));
			end
			sp_r = Q_NEG_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_wheel_q <= '0;
			acc_q        <= '0;
		end else begin
			if (cmd.in_load) begin
				prev_wheel_q <= w_c;
			end
			if (cmd.op == OP_ANG) begin
				acc_q <= acc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			tq_q      <= tq_n;
			inertia_q <= inertia_n;
			shaped_q  <= shaped_n;
			quick_q   <= quick_turn;
		end
		unique case (cmd.op)
			OP_MUL1, OP_MUL3, OP_MUL4: begin
				mul_q <= mul_res;
			end
			OP_MUL2: begin
				r2_q <= mul_res;
			end
			OP_TURN: begin
				turn_q <= sat_q(ext_t'(shaped_q) + ext_t'(mul_q));
			end
			OP_ANG: begin
				ang_q <= ang_n;
			end
			OP_SUM: begin
				left_q  <= sum_l;
				right_q <= sum_r;
			end
			OP_SPILL: begin
				left_q  <= sp_l;
				right_q <= sp_r;
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			left_drive_q  <= drive_out(left_q);
			right_drive_q <= drive_out(right_q);
		end
	end

	assign left_drive  = left_drive_q;
	assign right_drive = right_drive_q;

`ifndef SYNTHESIS
	a_prev_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		prev_wheel_q != -8'sd128)
		else $error("previous wheel holds an unclamped count");

	a_one_side_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_SPILL |=> (left_q <= Q_ONE && left_q >= Q_NEG_ONE) ||
			(right_q <= Q_ONE && right_q >= Q_NEG_ONE))
		else $error("both sides beyond full scale after the clamp step");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.out_load) |-> left_drive_q != -8'sd128 && right_drive_q != -8'sd128)
		else $error("motor command outside -127..127");
`endif

endmodule

// ===== rtl/core/curvature_drive_mixer.sv =====
// An accepted request steps through MUL1, TURN, MUL2, MUL3, MUL4, ANG, SUM,
// SPILL and FIN; until then in_stall holds off new requests, but one is taken
// while the previous result waits in the output register. The four dependent
// products go through one shared 24x24 multiplier, one product a cycle.
// Reset (arst_n low) clears the sequencer, the output valid, the previous wheel
// count and the quick-stop level; the shaping and count tables are constants.
module curvature_drive_mixer #(
	parameter int FRACTION_BITS = cdm_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [7:0] throttle,
	input  logic signed [7:0] wheel,
	input  logic              quick_turn,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [7:0] left_drive,
	output logic signed [7:0] right_drive
);
	import cdm_pkg::*;

	dp_cmd_t cmd;

	cdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	cdm_dp #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.throttle    (throttle),
		.wheel       (wheel),
		.quick_turn  (quick_turn),
		.left_drive  (left_drive),
		.right_drive (right_drive)
	);

endmodule
